// File: src/sdsf_pkg.sv
// ----------------------------------------------------------------------------
// sdsf_pkg: shared types and constants
// Word types, queue entry and segment patterns for the signed decimal
// seven-segment formatter.
// ----------------------------------------------------------------------------
package sdsf_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int IDX_W      = 3;

  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h01;
  localparam logic [7:0] SEG_POINT = 8'h80;

  // q = (v * DIV10_MAGIC) >> DIV10_SHIFT is exact for any 32-bit v
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_address;
    logic [7:0] segment_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [MAX_DIGITS-1:0][3:0] digits;
    logic [3:0]                 used;
    logic                       neg;
    logic                       ovf;
    logic                       fixed;
  } entry_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'h7E;
      4'd1: s = 8'h30;
      4'd2: s = 8'h6D;
      4'd3: s = 8'h79;
      4'd4: s = 8'h33;
      4'd5: s = 8'h5B;
      4'd6: s = 8'h5F;
      4'd7: s = 8'h70;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h7B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// File: src/signed_decimal_seven_segment_format.sv
// ----------------------------------------------------------------------------
// signed_decimal_seven_segment_format: signed value to display writes
// Each word in gives DIGITS digit-register writes, leftmost first.
//
//   channel | direction | handshake         | word
//   item    | in        | push / full       | in_word_t  (mode, value)
//   result  | out       | pop / empty       | out_word_t (digit_address,
//           |           |                   |   segment_byte, last)
//
// The output stage emits one write per cycle unless the result stalls;
// conversion peels one digit per cycle through a multiply-by-reciprocal
// divider, holding its last digit while the queue is full. A new word
// is taken in the cycle that the previous entry is pushed, or when idle.
// Synchronous active-high reset empties all stages; a stalled result
// holds, and input keeps flowing until the two-entry queue fills.
// ----------------------------------------------------------------------------
module signed_decimal_seven_segment_format
  import sdsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_word_t  item,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  logic   fq_push;
  logic   fq_full;
  entry_t fq_wdata;
  logic   qb_pop;
  logic   qb_empty;
  entry_t qb_rdata;

  sdsf_front #(
    .DIGITS(DIGITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_wdata)
  );

  sdsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_wdata),
    .pop     (qb_pop),
    .empty   (qb_empty),
    .rd_data (qb_rdata)
  );

  sdsf_back #(
    .DIGITS(DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (qb_empty),
    .q_pop   (qb_pop),
    .q_data  (qb_rdata),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: src/sdsf_front.sv
// ----------------------------------------------------------------------------
// sdsf_front: input stage and decimal conversion
// Takes a word, finds sign, magnitude and range, then peels one decimal
// digit per cycle and pushes the finished entry once the queue has room.
// ----------------------------------------------------------------------------
module sdsf_front
  import sdsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_word_t item,
  output logic     q_push,
  input  logic     q_full,
  output entry_t   q_data
);

  localparam int          CNT_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int          MAG_W   = $clog2(10 ** DIGITS);
  localparam logic [31:0] POS_MAX = 32'(10 ** DIGITS - 1);
  localparam logic [31:0] NEG_MAX = 32'(10 ** (DIGITS - 1) - 1);
  localparam logic [3:0]  MIN_FIX = 4'((DIGITS < 4) ? DIGITS : 4);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [MAG_W-1:0]           mag;
  logic                       neg;
  logic                       ovf;
  logic                       fixed;
  logic [MAX_DIGITS-1:0][3:0] digits;

  logic                       step_last;
  logic                       advance;
  logic                       accept;
  logic                       in_neg;
  logic [31:0]                in_mag;
  logic [63:0]                prod;
  logic [MAG_W-1:0]           quot;
  logic [MAG_W-1:0]           ten_q;
  logic [3:0]                 rem;
  logic [IDX_W-1:0]           cnt_idx;
  logic [MAX_DIGITS-1:0][3:0] merged;
  logic [3:0]                 used;

  assign step_last = busy && (cnt == CNT_W'(DIGITS - 1));
  assign advance   = busy && !(step_last && q_full);
  assign full      = busy && !(step_last && !q_full);
  assign accept    = push && !full;
  assign q_push    = step_last;

  assign in_neg = item.value[31];
  assign in_mag = in_neg ? (32'd0 - 32'(item.value)) : 32'(item.value);

  assign prod  = {32'd0, 32'(mag)} * {32'd0, DIV10_MAGIC};
  assign quot  = MAG_W'(prod[63:DIV10_SHIFT]);
  assign ten_q = (quot << 3) + (quot << 1);
  assign rem   = 4'(mag - ten_q);

  assign cnt_idx = IDX_W'(cnt);

  always_comb begin
    merged          = digits;
    merged[cnt_idx] = rem;
    used            = 4'd1;
    for (int i = 0; i < DIGITS; i++) begin
      if (merged[i] != 4'd0) begin
        used = 4'(i + 1);
      end
    end
    if (fixed && (used < MIN_FIX)) begin
      used = MIN_FIX;
    end
  end

  always_comb begin
    q_data.digits = merged;
    q_data.used   = used;
    q_data.neg    = neg;
    q_data.ovf    = ovf;
    q_data.fixed  = fixed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (advance) begin
        cnt <= cnt + CNT_W'(1);
        if (step_last) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      digits[cnt_idx] <= rem;
      mag             <= quot;
    end
    if (accept) begin
      digits <= '0;
      mag    <= MAG_W'(in_mag);
      neg    <= in_neg;
      ovf    <= in_neg ? (in_mag > NEG_MAX) : (in_mag > POS_MAX);
      fixed  <= item.mode;
    end
  end

endmodule

// File: src/sdsf_queue.sv
// ----------------------------------------------------------------------------
// sdsf_queue: two-entry queue
// Holds converted entries between the conversion and the output stages.
// ----------------------------------------------------------------------------
module sdsf_queue
  import sdsf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  entry_t wr_data,
  input  logic   pop,
  output logic   empty,
  output entry_t rd_data
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/sdsf_back.sv
// ----------------------------------------------------------------------------
// sdsf_back: digit formatter and output register
// Walks an entry from the leftmost position, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module sdsf_back
  import sdsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  output logic      q_pop,
  input  entry_t    q_data,
  output logic      empty,
  input  logic      pop,
  output out_word_t result
);

  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  entry_t           cur;
  logic             active;
  logic [CNT_W-1:0] k;
  logic             res_valid;
  out_word_t        res;

  logic             adv;
  logic             k_last;
  logic             load;
  logic [IDX_W-1:0] pos;
  logic [3:0]       pos4;
  logic [7:0]       seg;
  out_word_t        word_next;

  assign adv    = !res_valid || pop;
  assign k_last = (k == CNT_W'(DIGITS - 1));
  assign load   = !q_empty && (!active || (adv && k_last));
  assign q_pop  = load;
  assign empty  = !res_valid;
  assign result = res;

  assign pos  = IDX_W'(CNT_W'(DIGITS - 1) - k);
  assign pos4 = 4'(pos);

  always_comb begin
    if (cur.ovf) begin
      seg = SEG_MINUS;
    end else begin
      if (pos4 < cur.used) begin
        seg = seg_of(cur.digits[pos]);
      end else if ((pos4 == cur.used) && cur.neg) begin
        seg = SEG_MINUS;
      end else begin
        seg = SEG_BLANK;
      end
      if (cur.fixed && (DIGITS >= 4) && (pos == IDX_W'(3))) begin
        seg = seg | SEG_POINT;
      end
    end
    word_next.digit_address = pos4 + 4'd1;
    word_next.segment_byte  = seg;
    word_next.last          = k_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= active;
        if (active) begin
          k <= k + CNT_W'(1);
          if (k_last) begin
            active <= 1'b0;
          end
        end
      end
      if (load) begin
        active <= 1'b1;
        k      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && active) begin
      res <= word_next;
    end
    if (load) begin
      cur <= q_data;
    end
  end

endmodule

// File: test/display_write_checker.sv
// ----------------------------------------------------------------------------
// display_write_checker: scoreboard for the seven-segment formatter
// Watches both queue interfaces. Each accepted input word is expanded into
// the digit-register writes it should cause. Each accepted output word is
// checked field by field against the oldest outstanding write.
// ----------------------------------------------------------------------------
module display_write_checker
  import sdsf_pkg::*;
#(
  parameter int DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_word_t  item,
  input  logic      empty,
  input  logic      pop,
  input  out_word_t result,
  output int        errors,
  output int        pending,
  output int        words_in,
  output int        writes_out,
  output int        fixed_words,
  output int        range_overflows
);

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  out_word_t expected_writes [$];

  function automatic void predict_display_writes(input in_word_t w);
    logic [31:0] raw;
    logic [31:0] neg_raw;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] rem;
    logic        ovf;
    logic [3:0]  bcd [8];
    logic [7:0]  seg [8];
    int          used;
    int          minw;
    int          pos;
    out_word_t   wr;
    raw     = w.value;
    neg     = raw[31];
    neg_raw = ~raw + 32'd1;
    mag     = {32'd0, (neg ? neg_raw : raw)};
    lim     = 64'd1;
    for (int i = 0; i < DIGITS - 1; i++) lim = lim * 64'd10;
    ovf = neg ? (mag > lim - 64'd1) : (mag > lim * 64'd10 - 64'd1);
    if (w.mode) fixed_words++;
    if (ovf) begin
      range_overflows++;
      for (int i = 0; i < 8; i++) seg[i] = SEG_MINUS;
    end else begin
      rem  = mag;
      used = 1;
      for (int i = 0; i < 8; i++) begin
        bcd[i] = 4'(rem % 64'd10);
        rem    = rem / 64'd10;
      end
      for (int i = 0; i < 8; i++) if (bcd[i] != 4'd0) used = i + 1;
      if (w.mode) begin
        minw = (DIGITS < 4) ? DIGITS : 4;
        if (used < minw) used = minw;
      end
      if (used > DIGITS) used = DIGITS;
      for (int i = 0; i < 8; i++) begin
        if (i < used) seg[i] = DIGIT_SEGS[bcd[i]];
        else if (i == used && neg) seg[i] = SEG_MINUS;
        else seg[i] = SEG_BLANK;
      end
      if (w.mode && DIGITS >= 4) seg[3] = seg[3] | SEG_POINT;
    end
    for (int k = 0; k < DIGITS; k++) begin
      pos              = DIGITS - 1 - k;
      wr.digit_address = 4'(pos + 1);
      wr.segment_byte  = seg[pos];
      wr.last          = (k == DIGITS - 1);
      expected_writes.push_back(wr);
    end
  endfunction

  // sampled mid-cycle: inputs change at the rising edge only
  always @(negedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      errors          = 0;
      words_in        = 0;
      writes_out      = 0;
      fixed_words     = 0;
      range_overflows = 0;
    end else begin
      if (push && !full) begin
        predict_display_writes(item);
        words_in++;
      end
      if (pop && !empty) begin
        writes_out++;
        if (expected_writes.size() == 0) begin
          $error("unexpected word: digit_address %0d segment_byte %02h last %0b",
                 result.digit_address, result.segment_byte, result.last);
          errors++;
        end else begin
          want = expected_writes.pop_front();
          if (result.digit_address !== want.digit_address) begin
            $error("digit_address: expected %0d, actual %0d",
                   want.digit_address, result.digit_address);
            errors++;
          end
          if (result.segment_byte !== want.segment_byte) begin
            $error("segment_byte: expected %02h, actual %02h",
                   want.segment_byte, result.segment_byte);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, result.last);
            errors++;
          end
        end
      end
    end
    pending = expected_writes.size();
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: top of the seven-segment formatter testbench
// Drives signed values in both modes through the input queue and pops the
// digit writes with random back-pressure. A directed set covers zero, the
// range limits, the most negative value and the fixed-point point; random
// words follow, mostly in range with random digit counts. Checking is done
// by display_write_checker.
// ----------------------------------------------------------------------------
module tb;
  import sdsf_pkg::*;

  localparam int RANDOM_WORDS = 360;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 22;

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_word_t  item = '0;
  logic      full;
  logic      empty;
  out_word_t result;

  int errors;
  int pending;
  int words_in;
  int writes_out;
  int fixed_words;
  int range_overflows;

  bit steady    = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  signed_decimal_seven_segment_format u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  display_write_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .item            (item),
    .empty           (empty),
    .pop             (pop),
    .result          (result),
    .errors          (errors),
    .pending         (pending),
    .words_in        (words_in),
    .writes_out      (writes_out),
    .fixed_words     (fixed_words),
    .range_overflows (range_overflows)
  );

  // called right after a rising edge; returns at the edge that takes the word
  task automatic send_value(input logic m, input logic [31:0] v);
    bit taken;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= in_word_t'{mode: m, value: v};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int unsigned sel;
    int unsigned len;
    int unsigned span;
    sel = $urandom_range(99);
    if (sel < 12) begin
      v = $urandom();
    end else if (sel < 22) begin
      case ($urandom_range(5))
        0:       v = 32'd99999999;
        1:       v = 32'd100000000;
        2:       v = -32'sd9999999;
        3:       v = -32'sd10000000;
        4:       v = 32'd0;
        default: v = 32'h8000_0000;
      endcase
    end else begin
      len  = $urandom_range(1, 8);
      span = 1;
      for (int i = 0; i < len; i++) span = span * 10;
      v = $urandom_range(0, span - 1);
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_value(1'b0, 32'd0);
    send_value(1'b1, 32'd0);
    send_value(1'b0, 32'd1);
    send_value(1'b0, -32'sd1);
    send_value(1'b0, 32'd99999999);
    send_value(1'b0, 32'd100000000);
    send_value(1'b0, -32'sd9999999);
    send_value(1'b0, -32'sd10000000);
    send_value(1'b0, 32'd12345678);
    send_value(1'b0, -32'sd9876543);
    send_value(1'b0, 32'h7FFF_FFFF);
    send_value(1'b0, 32'h8000_0000);
    send_value(1'b1, 32'd5);
    send_value(1'b1, -32'sd5);
    send_value(1'b1, 32'd1234);
    send_value(1'b1, -32'sd999);
    send_value(1'b1, 32'd99999999);
    send_value(1'b1, -32'sd9999999);
    send_value(1'b1, -32'sd10000000);
    send_value(1'b0, 32'd10);
    send_value(1'b1, 32'd20000000);
    send_value(1'b0, 32'h5555_5555);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 200 && i < 280);
      if (i == 120) hold_req = 1'b1;
      if (i == 300) begin
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_value($urandom_range(1), random_value());
    end
    steady = 1'b0;
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d words (%0d fixed-point, %0d out of range) giving %0d digit writes,",
             words_in, fixed_words, range_overflows, writes_out);
    $display("including a %0d-cycle output stall and a full drain pause.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_done = 1'b1;
      end
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d writes still outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule
